// ===== hdl/tfb_pkg.sv =====
// Shared types, constants and the CRC-8 step of the telemetry frame builder.
package tfb_pkg;

  localparam int FRAME_LEN   = 15;
  localparam int IDX_W       = 4;
  localparam logic [IDX_W-1:0] IDX_FIRST = 4'd0;
  localparam logic [IDX_W-1:0] IDX_CRC   = 4'(FRAME_LEN - 1);

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] SYNC0    = 8'h4D;
  localparam logic [7:0] SYNC1    = 8'h41;

  // Servo scaling: 1.036 in Q24, offset 1.243 in Q24 shifted up to Q32.
  localparam int PROD_W = 42;
  localparam logic signed [25:0]       POS_MULT   = 26'sd17381196;
  localparam logic signed [PROD_W-1:0] POS_OFFSET = 42'sd5338644224;
  localparam logic [9:0]               POS_MAX    = 10'd100;

  localparam logic signed [7:0] IR_ON_BELOW   = -8'sd20;
  localparam logic signed [8:0] EO_SUM_ON_BELOW = -9'sd21;
  localparam logic signed [7:0] LENS_ON_BELOW = -8'sd15;
  localparam logic signed [7:0] COMP_ON_BELOW = -8'sd20;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_HEAT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ID     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_ID     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_ID  = 3'd4;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        auto_heat;
    logic [15:0] send_period_ms;
    logic [3:0]  node_id;
    logic [3:0]  dest_id;
    logic [7:0]  message_id;
  } cfg_t;

  typedef struct packed {
    logic [7:0] ir;
    logic [7:0] eo_first;
    logic [7:0] eo_second;
    logic [7:0] lens;
    logic [7:0] computer;
    logic [7:0] board;
    logic [7:0] room;
    logic [7:0] bc;
    logic [7:0] servo_pos;
    logic [7:0] servo_temp;
    logic       heat_ir;
    logic       heat_eo;
    logic       heat_lens;
    logic       heat_computer;
  } frame_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/telemetry_frame_builder_crc8.sv =====
// Top level of the telemetry frame builder: configuration registers and the three parts.
//
// Input side: a queue-like request port. Assert push with a tick (now_ms and the ten
// readings); the request is taken at a clock edge where push is high and full is low.
// A tick whose elapsed time (now_ms - last send, 32-bit wrap) does not exceed
// send_period_ms is absorbed and produces nothing; otherwise it produces a 15-byte frame.
// Output side: while empty is low the oldest byte sits on frame_byte with its flags;
// pop takes it. last_byte marks the CRC byte; heater bits appear on it when auto_heat is 1.
// Path: after the edge that takes the tick, the record passes the multiply register, the
// queue write and the output register before its first byte is visible. Throughput: one
// byte per cycle while pop stays high, set by the single-byte output register.
// Ticks that do not send are taken one per cycle while full is low; sending ticks queue
// in a two-entry record queue plus two front stages, so full rises only when the
// serializer falls behind. Stall: with pop low the output byte holds, the serializer
// stops, the queue fills and then full rises; nothing is dropped.
// Configuration: write_en with write_index and write_data writes one register at once;
// write only while the block is idle. Reset (rst, synchronous) restores the register
// defaults, clears the last send time and empties every stage.
module telemetry_frame_builder_crc8 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_en,
  input  logic [tfb_pkg::CFG_IDX_W-1:0]     write_index,
  input  logic [tfb_pkg::CFG_DATA_W-1:0]    write_data,
  input  logic                              push,
  output logic                              full,
  input  logic [31:0]                       now_ms,
  input  logic signed [7:0]                 temp_ambient,
  input  logic signed [7:0]                 temp_ir,
  input  logic signed [7:0]                 temp_eo_second,
  input  logic signed [7:0]                 temp_optic,
  input  logic signed [7:0]                 temp_eo_first,
  input  logic signed [7:0]                 temp_computer,
  input  logic signed [7:0]                 temp_bc,
  input  logic signed [7:0]                 temp_board,
  input  logic signed [15:0]                servo_pos_q8,
  input  logic signed [7:0]                 servo_temp,
  output logic                              empty,
  input  logic                              pop,
  output logic [7:0]                        frame_byte,
  output logic                              last_byte,
  output logic                              heaters_valid,
  output logic                              heater_ir,
  output logic                              heater_eo,
  output logic                              heater_lens,
  output logic                              heater_computer
);
  import tfb_pkg::*;

  cfg_t   cfg;
  logic   q_push;
  logic   q_full;
  frame_t q_in;
  logic   q_pop;
  logic   q_empty;
  frame_t q_head;

  // Register file; unused data bits and unknown indexes drop silently.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_heat      <= 1'b1;
      cfg.send_period_ms <= 16'd1000;
      cfg.node_id        <= 4'd7;
      cfg.dest_id        <= 4'd14;
      cfg.message_id     <= 8'd5;
    end else if (write_en) begin
      unique case (write_index)
        REG_AUTO_HEAT:   cfg.auto_heat      <= write_data[0];
        REG_SEND_PERIOD: cfg.send_period_ms <= write_data[15:0];
        REG_NODE_ID:     cfg.node_id        <= write_data[3:0];
        REG_DEST_ID:     cfg.dest_id        <= write_data[3:0];
        REG_MESSAGE_ID:  cfg.message_id     <= write_data[7:0];
        default: ;
      endcase
    end
  end

  // Front end: time check, capture, servo scaling.
  tfb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .push           (push),
    .full           (full),
    .now_ms         (now_ms),
    .temp_ambient   (temp_ambient),
    .temp_ir        (temp_ir),
    .temp_eo_second (temp_eo_second),
    .temp_optic     (temp_optic),
    .temp_eo_first  (temp_eo_first),
    .temp_computer  (temp_computer),
    .temp_bc        (temp_bc),
    .temp_board     (temp_board),
    .servo_pos_q8   (servo_pos_q8),
    .servo_temp     (servo_temp),
    .q_push         (q_push),
    .q_full         (q_full),
    .q_data         (q_in)
  );

  // Decouple the front end from the serializer.
  tfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .full      (q_full),
    .push_data (q_in),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Serializer with CRC and output register.
  tfb_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .frame_byte      (frame_byte),
    .last_byte       (last_byte),
    .heaters_valid   (heaters_valid),
    .heater_ir       (heater_ir),
    .heater_eo       (heater_eo),
    .heater_lens     (heater_lens),
    .heater_computer (heater_computer)
  );

endmodule

// ===== hdl/tfb_front.sv =====
// Front end: take ticks, decide on sending, scale the servo position, build a frame record.
module tfb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  tfb_pkg::cfg_t         cfg,
  input  logic                  push,
  output logic                  full,
  input  logic [31:0]           now_ms,
  input  logic signed [7:0]     temp_ambient,
  input  logic signed [7:0]     temp_ir,
  input  logic signed [7:0]     temp_eo_second,
  input  logic signed [7:0]     temp_optic,
  input  logic signed [7:0]     temp_eo_first,
  input  logic signed [7:0]     temp_computer,
  input  logic signed [7:0]     temp_bc,
  input  logic signed [7:0]     temp_board,
  input  logic signed [15:0]    servo_pos_q8,
  input  logic signed [7:0]     servo_temp,
  output logic                  q_push,
  input  logic                  q_full,
  output tfb_pkg::frame_t       q_data
);
  import tfb_pkg::*;

  logic [31:0]        last_send_ms;
  logic               s1_valid;
  frame_t             s1_frame;
  logic signed [15:0] s1_servo;
  logic               s2_valid;
  frame_t             s2_frame;
  logic signed [PROD_W-1:0] s2_prod;

  logic                     accept;
  logic                     send;
  logic [31:0]              elapsed;
  logic                     s2_free;
  logic                     s1_adv;
  logic signed [PROD_W-1:0] acc;
  logic signed [8:0]        eo_sum;
  logic [7:0]               pos_byte;

  assign elapsed = now_ms - last_send_ms;
  assign send    = elapsed > {16'd0, cfg.send_period_ms};
  assign s2_free = !s2_valid || !q_full;
  assign s1_adv  = s1_valid && s2_free;
  assign full    = s1_valid && !s2_free;
  assign accept  = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_send_ms <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
    end else begin
      if (accept && send) begin
        last_send_ms <= now_ms;
        s1_valid     <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_valid && !q_full) begin
        s2_valid <= 1'b0;
      end
    end
  end

  assign eo_sum = 9'(temp_eo_first) + 9'(temp_eo_second);

  // Capture a sending tick's readings and heater decisions, then form the servo product.
  always_ff @(posedge clk) begin
    if (accept && send) begin
      s1_frame.ir            <= temp_ir;
      s1_frame.eo_first      <= temp_eo_first;
      s1_frame.eo_second     <= temp_eo_second;
      s1_frame.lens          <= temp_optic;
      s1_frame.computer      <= temp_computer;
      s1_frame.board         <= temp_board;
      s1_frame.room          <= temp_ambient;
      s1_frame.bc            <= temp_bc;
      s1_frame.servo_pos     <= '0;
      s1_frame.servo_temp    <= servo_temp;
      s1_frame.heat_ir       <= temp_ir < IR_ON_BELOW;
      s1_frame.heat_eo       <= eo_sum < EO_SUM_ON_BELOW;
      s1_frame.heat_lens     <= temp_optic < LENS_ON_BELOW;
      s1_frame.heat_computer <= temp_computer < COMP_ON_BELOW;
      s1_servo               <= servo_pos_q8;
    end
    if (s1_adv) begin
      s2_frame <= s1_frame;
      s2_prod  <= PROD_W'(s1_servo) * PROD_W'(POS_MULT);
    end
  end

  // Offset, floor and clamp to 0..100.
  assign acc = s2_prod - POS_OFFSET;

  always_comb begin
    if (acc[PROD_W-1]) begin
      pos_byte = 8'd0;
    end else if (acc[PROD_W-1:32] > POS_MAX) begin
      pos_byte = POS_MAX[7:0];
    end else begin
      pos_byte = acc[39:32];
    end
  end

  always_comb begin
    q_data           = s2_frame;
    q_data.servo_pos = pos_byte;
  end

  assign q_push = s2_valid;

endmodule

// ===== hdl/tfb_queue.sv =====
// Two-entry queue of frame records between the front end and the serializer.
module tfb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  tfb_pkg::frame_t push_data,
  input  logic            pop,
  output logic            empty,
  output tfb_pkg::frame_t head
);
  import tfb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  frame_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  logic do_push;
  logic do_pop;

  assign full    = count == (PTR_W + 1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/tfb_back.sv =====
// Serializer: walk a frame record byte by byte, run the CRC, hold the output register.
module tfb_back (
  input  logic            clk,
  input  logic            rst,
  input  tfb_pkg::cfg_t   cfg,
  input  logic            q_empty,
  input  tfb_pkg::frame_t q_head,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      frame_byte,
  output logic            last_byte,
  output logic            heaters_valid,
  output logic            heater_ir,
  output logic            heater_eo,
  output logic            heater_lens,
  output logic            heater_computer
);
  import tfb_pkg::*;

  logic             out_valid;
  logic [IDX_W-1:0] idx;
  logic [7:0]       crc;

  logic       load;
  logic       at_crc;
  logic [7:0] data_byte;
  logic [7:0] crc_seed;

  assign load   = (!out_valid || pop) && !q_empty;
  assign at_crc = idx == IDX_CRC;
  assign q_pop  = load && at_crc;
  assign empty  = !out_valid;

  always_comb begin
    case (idx)
      4'd0:    data_byte = SYNC0;
      4'd1:    data_byte = SYNC1;
      4'd2:    data_byte = {cfg.node_id, cfg.dest_id};
      4'd3:    data_byte = cfg.message_id;
      4'd4:    data_byte = q_head.ir;
      4'd5:    data_byte = q_head.eo_first;
      4'd6:    data_byte = q_head.eo_second;
      4'd7:    data_byte = q_head.lens;
      4'd8:    data_byte = q_head.computer;
      4'd9:    data_byte = q_head.board;
      4'd10:   data_byte = q_head.room;
      4'd11:   data_byte = q_head.bc;
      4'd12:   data_byte = q_head.servo_pos;
      4'd13:   data_byte = q_head.servo_temp;
      default: data_byte = crc;
    endcase
  end

  assign crc_seed = (idx == IDX_FIRST) ? CRC_INIT : crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= IDX_FIRST;
      crc       <= CRC_INIT;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_crc ? IDX_FIRST : idx + 1'b1;
        if (!at_crc) begin
          crc <= crc8_update(crc_seed, data_byte);
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte      <= data_byte;
      last_byte       <= at_crc;
      heaters_valid   <= at_crc && cfg.auto_heat;
      heater_ir       <= at_crc && cfg.auto_heat && q_head.heat_ir;
      heater_eo       <= at_crc && cfg.auto_heat && q_head.heat_eo;
      heater_lens     <= at_crc && cfg.auto_heat && q_head.heat_lens;
      heater_computer <= at_crc && cfg.auto_heat && q_head.heat_computer;
    end
  end

endmodule

// ===== hdl/tfb_checker.sv =====
// Port-level checks of the frame builder and the bind that attaches them.
module tfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] frame_byte,
  input logic       last_byte,
  input logic       heaters_valid,
  input logic       heater_ir,
  input logic       heater_eo,
  input logic       heater_lens,
  input logic       heater_computer
);

  // Reset leaves nothing to take.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // Heater status only rides on the CRC byte.
  a_heat_on_last: assert property (@(posedge clk) disable iff (rst)
    !empty && heaters_valid |-> last_byte)
    else $error("heaters_valid away from the CRC byte");

  // Heater bits stay low unless they are marked valid.
  a_heat_bits: assert property (@(posedge clk) disable iff (rst)
    !empty && !heaters_valid |->
      !(heater_ir || heater_eo || heater_lens || heater_computer))
    else $error("heater bit set without heaters_valid");

  // A stalled byte holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(frame_byte) && $stable(last_byte))
    else $error("output changed under stall");

endmodule

bind telemetry_frame_builder_crc8 tfb_checker u_tfb_checker (
  .clk             (clk),
  .rst             (rst),
  .empty           (empty),
  .pop             (pop),
  .frame_byte      (frame_byte),
  .last_byte       (last_byte),
  .heaters_valid   (heaters_valid),
  .heater_ir       (heater_ir),
  .heater_eo       (heater_eo),
  .heater_lens     (heater_lens),
  .heater_computer (heater_computer)
);

// ===== tb/sv/tb_telemetry_frame_builder_crc8.sv =====
// Self-checking testbench for the telemetry frame builder with CRC-8 trailer.
module tb_telemetry_frame_builder_crc8;
  import tfb_pkg::*;

  // Frame layout and arithmetic, kept separate from the design's own package values.
  localparam int              BYTES_PER_FRAME  = 15;
  localparam logic [7:0]      SYNC_FIRST       = 8'h4D;
  localparam logic [7:0]      SYNC_SECOND      = 8'h41;
  localparam logic [7:0]      CRC8_SEED        = 8'hFF;
  localparam logic [7:0]      CRC8_POLY        = 8'h31;
  localparam longint          SERVO_GAIN_Q24   = 64'sd17381196;
  localparam longint          SERVO_OFFSET_Q32 = 64'sd5338644224;
  localparam longint          SERVO_PCT_MAX    = 64'sd100;
  localparam int              IR_HEAT_BELOW    = -20;
  localparam int              EO_HEAT_BELOW    = -10;
  localparam int              LENS_HEAT_BELOW  = -15;
  localparam int              COMP_HEAT_BELOW  = -20;

  // Indexes past the last register; writes there must leave everything alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int RESET_CYCLES      = 8;
  localparam int SETTLE_CYCLES     = 16;
  localparam int DRAIN_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT       = 400000;

  typedef struct packed {
    logic [31:0] now;
    logic [7:0]  room;
    logic [7:0]  ir;
    logic [7:0]  eo_second;
    logic [7:0]  lens;
    logic [7:0]  eo_first;
    logic [7:0]  computer;
    logic [7:0]  bc;
    logic [7:0]  board;
    logic [15:0] servo;
    logic [7:0]  servo_temp;
  } tick_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       heat_valid;
    logic       heat_ir;
    logic       heat_eo;
    logic       heat_lens;
    logic       heat_computer;
  } frame_out_t;

  // Mirror of the framer: register copy, last send time and the bytes still owed.
  class frame_tracker;
    logic        auto_heat;
    logic [15:0] period;
    logic [3:0]  node;
    logic [3:0]  receiver;
    logic [7:0]  msg_id;
    logic [31:0] last_send;
    frame_out_t  bytes_due[$];
    int          fail_count;

    function new();
      auto_heat  = 1'b1;
      period     = 16'd1000;
      node       = 4'd7;
      receiver   = 4'd14;
      msg_id     = 8'd5;
      last_send  = 32'd0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_AUTO_HEAT:   auto_heat = value[0];
        REG_SEND_PERIOD: period    = value[15:0];
        REG_NODE_ID:     node      = value[3:0];
        REG_DEST_ID:     receiver  = value[3:0];
        REG_MESSAGE_ID:  msg_id    = value[7:0];
        default: ;
      endcase
    endfunction

    // Accepted tick: queue the 15 bytes it sends, if it sends at all.
    function void note_tick(tick_t t);
      logic [7:0]  frame [BYTES_PER_FRAME];
      logic [7:0]  crc;
      logic [31:0] elapsed;
      longint      acc;
      int          eo_mean;
      frame_out_t  b;

      elapsed = t.now - last_send;
      if (elapsed <= 32'(period)) return;
      last_send = t.now;

      acc = longint'($signed(t.servo)) * SERVO_GAIN_Q24 - SERVO_OFFSET_Q32;
      frame[0]  = SYNC_FIRST;
      frame[1]  = SYNC_SECOND;
      frame[2]  = {node, receiver};
      frame[3]  = msg_id;
      frame[4]  = t.ir;
      frame[5]  = t.eo_first;
      frame[6]  = t.eo_second;
      frame[7]  = t.lens;
      frame[8]  = t.computer;
      frame[9]  = t.board;
      frame[10] = t.room;
      frame[11] = t.bc;
      if (acc < 0) frame[12] = 8'd0;
      else if ((acc >>> 32) > SERVO_PCT_MAX) frame[12] = 8'(SERVO_PCT_MAX);
      else frame[12] = 8'(acc >>> 32);
      frame[13] = t.servo_temp;

      crc = CRC8_SEED;
      for (int i = 0; i < BYTES_PER_FRAME - 1; i++) begin
        crc = crc ^ frame[i];
        for (int k = 0; k < 8; k++) crc = crc[7] ? ((crc << 1) ^ CRC8_POLY) : (crc << 1);
      end
      frame[BYTES_PER_FRAME-1] = crc;

      for (int i = 0; i < BYTES_PER_FRAME; i++) begin
        b = '0;
        b.data = frame[i];
        if (i == BYTES_PER_FRAME - 1) begin
          b.last = 1'b1;
          if (auto_heat) begin
            // Mean truncates toward zero, as integer division does.
            eo_mean         = (int'($signed(t.eo_first)) + int'($signed(t.eo_second))) / 2;
            b.heat_valid    = 1'b1;
            b.heat_ir       = int'($signed(t.ir)) < IR_HEAT_BELOW;
            b.heat_eo       = eo_mean < EO_HEAT_BELOW;
            b.heat_lens     = int'($signed(t.lens)) < LENS_HEAT_BELOW;
            b.heat_computer = int'($signed(t.computer)) < COMP_HEAT_BELOW;
          end
        end
        bytes_due.push_back(b);
      end
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        fail_count++;
      end
    endfunction

    function void check_byte(frame_out_t got);
      frame_out_t want;
      if (bytes_due.size() == 0) begin
        $error("frame_byte: nothing pending, got 0x%0h", got.data);
        fail_count++;
        return;
      end
      want = bytes_due.pop_front();
      compare("frame_byte", want.data, got.data);
      compare("last_byte", want.last, got.last);
      compare("heaters_valid", want.heat_valid, got.heat_valid);
      compare("heater_ir", want.heat_ir, got.heat_ir);
      compare("heater_eo", want.heat_eo, got.heat_eo);
      compare("heater_lens", want.heat_lens, got.heat_lens);
      compare("heater_computer", want.heat_computer, got.heat_computer);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   write_en;
  logic [CFG_IDX_W-1:0]   write_index;
  logic [CFG_DATA_W-1:0]  write_data;
  logic                   push;
  logic                   full;
  logic [31:0]            now_ms;
  logic signed [7:0]      temp_ambient;
  logic signed [7:0]      temp_ir;
  logic signed [7:0]      temp_eo_second;
  logic signed [7:0]      temp_optic;
  logic signed [7:0]      temp_eo_first;
  logic signed [7:0]      temp_computer;
  logic signed [7:0]      temp_bc;
  logic signed [7:0]      temp_board;
  logic signed [15:0]     servo_pos_q8;
  logic signed [7:0]      servo_temp;
  logic                   empty;
  logic                   pop;
  logic [7:0]             frame_byte;
  logic                   last_byte;
  logic                   heaters_valid;
  logic                   heater_ir;
  logic                   heater_eo;
  logic                   heater_lens;
  logic                   heater_computer;

  frame_tracker sb;
  int           cycles = 0;
  bit           drain_hold_req = 1'b0;

  telemetry_frame_builder_crc8 uut (
    .clk             (clk),
    .rst             (rst),
    .write_en        (write_en),
    .write_index     (write_index),
    .write_data      (write_data),
    .push            (push),
    .full            (full),
    .now_ms          (now_ms),
    .temp_ambient    (temp_ambient),
    .temp_ir         (temp_ir),
    .temp_eo_second  (temp_eo_second),
    .temp_optic      (temp_optic),
    .temp_eo_first   (temp_eo_first),
    .temp_computer   (temp_computer),
    .temp_bc         (temp_bc),
    .temp_board      (temp_board),
    .servo_pos_q8    (servo_pos_q8),
    .servo_temp      (servo_temp),
    .empty           (empty),
    .pop             (pop),
    .frame_byte      (frame_byte),
    .last_byte       (last_byte),
    .heaters_valid   (heaters_valid),
    .heater_ir       (heater_ir),
    .heater_eo       (heater_eo),
    .heater_lens     (heater_lens),
    .heater_computer (heater_computer)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Temperatures cluster near the heater thresholds a quarter of the time.
  function automatic logic [7:0] rand_temp();
    if ($urandom_range(0, 3) == 0) return 8'(-$urandom_range(5, 25));
    return 8'($urandom);
  endfunction

  // Servo values aim at the zero cutoff and the clamp as well as the whole range.
  function automatic logic [15:0] rand_servo();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(280, 340));
      2: return 16'($urandom_range(24990, 25050));
      default: return 16'($urandom_range(0, 26000));
    endcase
  endfunction

  function automatic tick_t random_tick(logic [31:0] when);
    tick_t t;
    t.now        = when;
    t.room       = rand_temp();
    t.ir         = rand_temp();
    t.eo_second  = rand_temp();
    t.lens       = rand_temp();
    t.eo_first   = rand_temp();
    t.computer   = rand_temp();
    t.bc         = rand_temp();
    t.board      = rand_temp();
    t.servo      = rand_servo();
    t.servo_temp = rand_temp();
    return t;
  endfunction

  // Mostly ticks that send, some that fall inside the period, some arbitrary times.
  function automatic logic [31:0] next_time();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return sb.last_send + 32'(sb.period) + 32'd1 + 32'($urandom_range(0, 40));
    if (pick < 85) return sb.last_send + 32'($urandom_range(0, sb.period));
    return $urandom;
  endfunction

  // Offer one request and hold it until the block takes it. Push stays high on return.
  task automatic send_tick(tick_t t);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    now_ms         <= t.now;
    temp_ambient   <= t.room;
    temp_ir        <= t.ir;
    temp_eo_second <= t.eo_second;
    temp_optic     <= t.lens;
    temp_eo_first  <= t.eo_first;
    temp_computer  <= t.computer;
    temp_bc        <= t.bc;
    temp_board     <= t.board;
    servo_pos_q8   <= t.servo;
    servo_temp     <= t.servo_temp;
    do @(posedge clk); while (full);
    sb.note_tick(t);
  endtask

  // Drop push, wait for every owed byte, then let the block idle before the next phase.
  task automatic settle();
    push <= 1'b0;
    while (sb.bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    sb.write_reg(idx, value);
    @(posedge clk);
    write_en    <= 1'b1;
    write_index <= idx;
    write_data  <= value;
    @(posedge clk);
    write_en    <= 1'b0;
  endtask

  task automatic random_phase(int count);
    repeat (count) send_tick(random_tick(next_time()));
    settle();
  endtask

  // Receiver: alternate pop bursts and idle gaps; honor one long hold when asked.
  initial begin
    bit pop_on;
    int run_left;
    pop_on   = 1'b0;
    run_left = 0;
    pop      = 1'b0;
    forever begin
      @(posedge clk);
      if (drain_hold_req) begin
        pop <= 1'b0;
        repeat (DRAIN_HOLD_CYCLES) @(posedge clk);
        drain_hold_req = 1'b0;
        run_left       = 0;
        pop_on         = 1'b0;
      end else begin
        if (run_left <= 0) begin
          pop_on   = !pop_on;
          run_left = pop_on ? $urandom_range(1, 40) : 1 + idle_gap();
        end
        pop <= pop_on;
        run_left--;
      end
    end
  end

  // Check each byte taken off the output side against the oldest owed byte.
  always @(posedge clk) begin
    frame_out_t got;
    if (!rst && pop && !empty) begin
      got = {frame_byte, last_byte, heaters_valid,
             heater_ir, heater_eo, heater_lens, heater_computer};
      sb.check_byte(got);
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    tick_t t;
    sb             = new();
    rst            = 1'b1;
    write_en       = 1'b0;
    write_index    = '0;
    write_data     = '0;
    push           = 1'b0;
    now_ms         = '0;
    temp_ambient   = '0;
    temp_ir        = '0;
    temp_eo_second = '0;
    temp_optic     = '0;
    temp_eo_first  = '0;
    temp_computer  = '0;
    temp_bc        = '0;
    temp_board     = '0;
    servo_pos_q8   = '0;
    servo_temp     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset register values (period 1000 ms).
    // Same time as the cleared last send, then exactly one period: neither sends.
    send_tick(random_tick(32'd0));
    send_tick(random_tick(32'd1000));
    // Most negative and most positive readings.
    t = random_tick(32'd1001);
    {t.room, t.ir, t.eo_second, t.lens, t.eo_first, t.computer, t.bc, t.board,
     t.servo_temp} = {9{8'h80}};
    t.servo = 16'h8000;
    send_tick(t);
    t = random_tick(32'd2002);
    {t.room, t.ir, t.eo_second, t.lens, t.eo_first, t.computer, t.bc, t.board,
     t.servo_temp} = {9{8'h7F}};
    t.servo = 16'h7FFF;
    send_tick(t);
    // Servo position around the negative cutoff and around the clamp at 100.
    t = random_tick(32'd3003);  t.servo = 16'd307;   send_tick(t);
    t = random_tick(32'd4004);  t.servo = 16'd308;   send_tick(t);
    t = random_tick(32'd5005);  t.servo = 16'd25017; send_tick(t);
    t = random_tick(32'd6006);  t.servo = 16'd25018; send_tick(t);
    // Heaters exactly at their thresholds: all stay off.
    t = random_tick(32'd7007);
    t.ir = -8'sd20; t.eo_first = -8'sd21; t.eo_second = 8'sd0;
    t.lens = -8'sd15; t.computer = -8'sd20;
    send_tick(t);
    // One step below every threshold: all come on.
    t = random_tick(32'd8008);
    t.ir = -8'sd21; t.eo_first = -8'sd21; t.eo_second = -8'sd1;
    t.lens = -8'sd16; t.computer = -8'sd21;
    send_tick(t);
    // Optical mean driven by the second camera alone.
    t = random_tick(32'd9009);  t.eo_first = 8'sd0;   t.eo_second = -8'sd22; send_tick(t);
    // Mean of -10.5 truncates to -10, so the optical heater stays off.
    t = random_tick(32'd10010); t.eo_first = -8'sd23; t.eo_second = 8'sd2;   send_tick(t);
    // Time near the top of the range, then across the wrap.
    send_tick(random_tick(32'hFFFF_FFF0));
    send_tick(random_tick(32'h0000_0010));
    send_tick(random_tick(32'h0000_03D8));
    send_tick(random_tick(32'h0000_03D9));
    // Time going back by one wraps to a huge gap and sends; repeating it does not.
    send_tick(random_tick(32'h0000_03D8));
    send_tick(random_tick(32'h0000_03D8));
    settle();

    // Zero period, heaters off, outer header values; stray bits and spare indexes.
    write_cfg(REG_AUTO_HEAT, {15'($urandom), 1'b0});
    write_cfg(REG_SEND_PERIOD, 16'd0);
    write_cfg(REG_NODE_ID, {12'($urandom), 4'hF});
    write_cfg(REG_DEST_ID, {12'($urandom), 4'h0});
    write_cfg(REG_MESSAGE_ID, {8'($urandom), 8'hFF});
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) begin
      write_cfg(CFG_IDX_W'(i), 16'($urandom));
    end
    // Hold the output side for a long stretch so the block backs up and raises full.
    drain_hold_req = 1'b1;
    random_phase(35);

    // Longest period with the opposite header extremes.
    write_cfg(REG_AUTO_HEAT, 16'd1);
    write_cfg(REG_SEND_PERIOD, 16'hFFFF);
    write_cfg(REG_NODE_ID, 16'd0);
    write_cfg(REG_DEST_ID, 16'd15);
    write_cfg(REG_MESSAGE_ID, 16'd0);
    random_phase(35);

    // Two random settings: one with a short period, one anywhere in range.
    write_cfg(REG_AUTO_HEAT, 16'($urandom));
    write_cfg(REG_SEND_PERIOD, 16'($urandom_range(0, 200)));
    write_cfg(REG_NODE_ID, 16'($urandom));
    write_cfg(REG_DEST_ID, 16'($urandom));
    write_cfg(REG_MESSAGE_ID, 16'($urandom));
    random_phase(40);

    write_cfg(REG_AUTO_HEAT, 16'($urandom));
    write_cfg(REG_SEND_PERIOD, 16'($urandom));
    write_cfg(REG_NODE_ID, 16'($urandom));
    write_cfg(REG_DEST_ID, 16'($urandom));
    write_cfg(REG_MESSAGE_ID, 16'($urandom));
    random_phase(40);

    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tfb_pkg.sv
hdl/tfb_front.sv
hdl/tfb_queue.sv
hdl/tfb_back.sv
hdl/telemetry_frame_builder_crc8.sv
hdl/tfb_checker.sv
tb/sv/tb_telemetry_frame_builder_crc8.sv
